// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file rdc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clock edge outside reset.
`define RDC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Check cons in the cycle after ante, outside reset.
`define RDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/rdc_pkg.sv -----
package rdc_pkg;

  localparam int unsigned RadixW  = 5;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned CharW   = 7;
  localparam int unsigned MDataW  = 8;

  localparam logic [RadixW-1:0] RadixMin = 5'd2;
  localparam logic [RadixW-1:0] RadixMax = 5'd16;

  localparam logic [CharW-1:0] DigitZero = 7'd48;
  localparam logic [CharW-1:0] LetterA   = 7'd65;

  function automatic logic [CharW-1:0] digit_to_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d < 4'd10) begin
      c = DigitZero + CharW'(d);
    end else begin
      c = LetterA + CharW'(d) - 7'd10;
    end
    return c;
  endfunction

endpackage

// ----- rtl/radix_digit_converter.sv -----
// Converts a non-negative integer to ASCII digits ('0'-'9', 'A'-'F') in a radix of 2 to
// 16, most significant digit first, no leading zeros, tlast on the final digit; zero gives
// a single '0', a radix below 2 acts as 2 and one above 16 as 16. Each digit comes from a
// bit-serial restoring division of the running quotient by the radix, one quotient bit per
// cycle over all VALUE_BITS bits; once every digit is on the stack, the digits are emitted
// one at a time while the output is free; the next item is taken in the cycle after the
// last digit has moved into the output register.
module radix_digit_converter #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // value [VALUE_BITS-1:0], radix [VALUE_BITS+4:VALUE_BITS], zero pad above
  input  logic [((VALUE_BITS + rdc_pkg::RadixW + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // digit_char [6:0], zero pad [7]
  output logic [rdc_pkg::MDataW-1:0] m_axis_tdata_o,
  output logic                       m_axis_tlast_o
);
  import rdc_pkg::*;

  localparam int unsigned CntW = $clog2(VALUE_BITS);
  localparam int unsigned NdW  = $clog2(VALUE_BITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e               state_q, state_d;
  logic [VALUE_BITS-1:0] work_q, work_d;
  logic [DigitW-1:0]     rem_q, rem_d;
  logic [RadixW-1:0]     radix_q, radix_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [NdW-1:0]        ndig_q, ndig_d;
  logic                  nz_q, nz_d;
  logic                  m_valid_q, m_valid_d;
  logic [CharW-1:0]      m_char_q, m_char_d;
  logic                  m_last_q, m_last_d;
  logic [DigitW-1:0]     dstack_q [VALUE_BITS];
  logic [DigitW-1:0]     dstack_d [VALUE_BITS];

  logic [RadixW-1:0] in_radix;
  logic [DigitW:0]   trial;
  logic              qbit;
  logic [DigitW-1:0] rem_nx;
  logic              s_hs;
  logic              out_free;
  logic              push;
  logic              pop;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_hs            = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_char_q};
  assign m_axis_tlast_o  = m_last_q;

  assign in_radix = s_axis_tdata_i[VALUE_BITS +: RadixW];
  assign trial    = {rem_q, work_q[VALUE_BITS-1]};
  assign qbit     = (trial >= radix_q);
  assign rem_nx   = qbit ? DigitW'(trial - radix_q) : trial[DigitW-1:0];
  assign push     = (state_q == ST_DIV) && (cnt_q == CntW'(VALUE_BITS - 1));
  assign pop      = (state_q == ST_EMIT) && out_free;

  always_comb begin
    state_d   = state_q;
    work_d    = work_q;
    rem_d     = rem_q;
    radix_d   = radix_q;
    cnt_d     = cnt_q;
    ndig_d    = ndig_q;
    nz_d      = nz_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_char_d  = m_char_q;
    m_last_d  = m_last_q;
    case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          work_d = s_axis_tdata_i[VALUE_BITS-1:0];
          if (in_radix < RadixMin) begin
            radix_d = RadixMin;
          end else if (in_radix > RadixMax) begin
            radix_d = RadixMax;
          end else begin
            radix_d = in_radix;
          end
          rem_d   = '0;
          cnt_d   = '0;
          nz_d    = 1'b0;
          ndig_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        work_d = {work_q[VALUE_BITS-2:0], qbit};
        rem_d  = rem_nx;
        nz_d   = nz_q | qbit;
        cnt_d  = cnt_q + 1'b1;
        if (push) begin
          ndig_d = ndig_q + 1'b1;
          rem_d  = '0;
          cnt_d  = '0;
          nz_d   = 1'b0;
          if (!(nz_q || qbit)) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_char_d  = digit_to_char(dstack_q[0]);
          m_last_d  = (ndig_q == NdW'(1));
          ndig_d    = ndig_q - 1'b1;
          if (ndig_q == NdW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < VALUE_BITS; i++) begin
      dstack_d[i] = dstack_q[i];
    end
    if (push) begin
      dstack_d[0] = rem_nx;
      for (int i = 1; i < VALUE_BITS; i++) begin
        dstack_d[i] = dstack_q[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        dstack_d[i] = dstack_q[i+1];
      end
      dstack_d[VALUE_BITS-1] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      ndig_q    <= '0;
      nz_q      <= 1'b0;
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ndig_q    <= ndig_d;
      nz_q      <= nz_d;
      m_valid_q <= m_valid_d;
      m_last_q  <= m_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q   <= work_d;
    rem_q    <= rem_d;
    radix_q  <= radix_d;
    m_char_q <= m_char_d;
    for (int i = 0; i < VALUE_BITS; i++) begin
      dstack_q[i] <= dstack_d[i];
    end
  end

endmodule

// ----- rtl/rdc_checker.sv -----
`include "assert_macros.svh"

module rdc_checker #(
  parameter int unsigned VALUE_BITS = 31
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  // digit_char [6:0], zero pad [7]
  input logic [rdc_pkg::MDataW-1:0] m_axis_tdata_o,
  input logic                       m_axis_tlast_o
);
  import rdc_pkg::*;

  logic s_hs;
  logic m_hs;
  logic first_q;
  logic is_digit;
  logic is_letter;

  assign s_hs      = s_axis_tvalid_i && s_axis_tready_o;
  assign m_hs      = m_axis_tvalid_o && m_axis_tready_i;
  assign is_digit  = (m_axis_tdata_o[CharW-1:0] >= DigitZero) &&
                     (m_axis_tdata_o[CharW-1:0] <= DigitZero + 7'd9);
  assign is_letter = (m_axis_tdata_o[CharW-1:0] >= LetterA) &&
                     (m_axis_tdata_o[CharW-1:0] <= LetterA + 7'd5);

  // Mark the first digit of each item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b0;
    end else if (s_hs) begin
      first_q <= 1'b1;
    end else if (m_hs) begin
      first_q <= 1'b0;
    end
  end

  `RDC_ASSERT(a_char_range, clk_i, rst_ni, !m_axis_tvalid_o || ((is_digit || is_letter) && !m_axis_tdata_o[CharW]))
  `RDC_ASSERT(a_no_lead_zero, clk_i, rst_ni, !(m_axis_tvalid_o && first_q && m_axis_tdata_o[CharW-1:0] == DigitZero) || m_axis_tlast_o)
  `RDC_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, s_hs, !s_axis_tready_o)
  `RDC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))

endmodule

bind radix_digit_converter rdc_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_rdc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
